// ===== rtl/u16u8_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// u16u8_pkg
// shared types and constants of the utf-16 to utf-8 encoder
// ---------------------------------------------------------------------------
package u16u8_pkg;

	localparam int unsigned MAX_BYTES     = 6;
	localparam int unsigned BYTE_IDX_W    = 3;
	localparam int unsigned QUEUE_DEPTH   = 2;

	localparam logic [15:0] LIMIT_ONE     = 16'h0080;
	localparam logic [15:0] LIMIT_TWO     = 16'h0800;
	localparam logic [15:0] HIGH_FIRST    = 16'hD800;
	localparam logic [15:0] HIGH_LAST     = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST     = 16'hDC00;
	localparam logic [15:0] LOW_LAST      = 16'hDFFF;
	localparam logic [20:0] PLANE_OFFSET  = 21'h10000;
	localparam logic [7:0]  CONT_MARK     = 8'h80;
	localparam logic [7:0]  LEAD_TWO      = 8'hC0;
	localparam logic [7:0]  LEAD_THREE    = 8'hE0;
	localparam logic [7:0]  LEAD_FOUR     = 8'hF0;

	// one queued job: bytes of one unit transfer, in emit order
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [BYTE_IDX_W-1:0]     count;
		logic                      fin;
	} u16u8_job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} u16u8_qstat_t;

endpackage : u16u8_pkg
`default_nettype wire

// ===== rtl/utf16_to_utf8_encoder_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utf16_to_utf8_encoder_top
// utf-16 code units in, utf-8 bytes out
// ---------------------------------------------------------------------------
// input channel: unit_valid / unit_stall carry code_unit and final_unit, one
// code unit per transfer. output channel: byte_valid / byte_stall carry one
// byte per transfer with run_last (last byte of a unit) and string_end.
// the front pairs surrogates and pushes one job of 1 to 6 bytes per unit
// into a short queue; a high surrogate that waits for its partner pushes
// nothing. the back sends one byte per cycle from a registered output
// while the queue holds a job and byte_stall is low. the first byte of a
// unit passes through the queue and then the output register. a unit
// yields as many bytes as its job holds (1 to 3, 4 for a pair, 3 to 6 for
// a flushed surrogate plus a unit); the back's byte rate bounds the output.
// reset clears the held surrogate, the queue pointers and count, and the output valid bit.
// a stalled output holds its byte; the queue fills and then unit_stall rises.
// ---------------------------------------------------------------------------
module utf16_to_utf8_encoder_top #(
	parameter int unsigned QueueDepth = u16u8_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        unit_valid,
	output logic             unit_stall,
	input  wire logic [15:0] code_unit,
	input  wire logic        final_unit,
	output logic             byte_valid,
	input  wire logic        byte_stall,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             string_end
);
	import u16u8_pkg::*;

	u16u8_job_t   push_job;
	u16u8_job_t   head;
	u16u8_qstat_t qstat;
	logic         push;
	logic         pop;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.qstat      (qstat),
		.push       (push),
		.job        (push_job)
	);

	u16u8_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule : utf16_to_utf8_encoder_top
`default_nettype wire

// ===== rtl/u16u8_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// u16u8_front
// accepts code units, pairs surrogates and builds the byte job for each unit
// ---------------------------------------------------------------------------
module u16u8_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   unit_valid,
	output logic                        unit_stall,
	input  wire logic [15:0]            code_unit,
	input  wire logic                   final_unit,
	input  wire u16u8_pkg::u16u8_qstat_t qstat,
	output logic                        push,
	output u16u8_pkg::u16u8_job_t       job
);
	import u16u8_pkg::*;

	logic [9:0]  held_high_q;
	logic        held_valid_q;
	logic        is_high;
	logic        is_low;
	logic        accept;
	logic        pair;
	logic        hold_new;
	logic [20:0] cp;
	logic [15:0] flush_unit;
	logic [2:0][7:0] new_bytes;
	logic [1:0]  new_count;
	logic [2:0][7:0] flush_bytes;

	assign is_high    = (code_unit >= HIGH_FIRST) && (code_unit <= HIGH_LAST);
	assign is_low     = (code_unit >= LOW_FIRST) && (code_unit <= LOW_LAST);
	assign pair       = held_valid_q && is_low;
	assign hold_new   = is_high && !final_unit;
	assign cp         = {1'b0, held_high_q, code_unit[9:0]} + PLANE_OFFSET;
	assign flush_unit = HIGH_FIRST | {6'd0, held_high_q};

	assign unit_stall = qstat.full;
	assign accept     = unit_valid && !unit_stall;

	assign flush_bytes[0] = LEAD_THREE | {4'd0, flush_unit[15:12]};
	assign flush_bytes[1] = CONT_MARK | {2'd0, flush_unit[11:6]};
	assign flush_bytes[2] = CONT_MARK | {2'd0, flush_unit[5:0]};

	always_comb begin
		new_bytes = '0;
		new_count = 2'd0;
		if (hold_new) begin
			new_count = 2'd0;
		end else if (code_unit < LIMIT_ONE) begin
			new_bytes[0] = code_unit[7:0];
			new_count    = 2'd1;
		end else if (code_unit < LIMIT_TWO) begin
			new_bytes[0] = LEAD_TWO | {2'd0, code_unit[11:6]};
			new_bytes[1] = CONT_MARK | {2'd0, code_unit[5:0]};
			new_count    = 2'd2;
		end else begin
			new_bytes[0] = LEAD_THREE | {4'd0, code_unit[15:12]};
			new_bytes[1] = CONT_MARK | {2'd0, code_unit[11:6]};
			new_bytes[2] = CONT_MARK | {2'd0, code_unit[5:0]};
			new_count    = 2'd3;
		end
	end

	always_comb begin
		job       = '0;
		job.fin   = final_unit;
		if (pair) begin
			job.bytes[0] = LEAD_FOUR | {5'd0, cp[20:18]};
			job.bytes[1] = CONT_MARK | {2'd0, cp[17:12]};
			job.bytes[2] = CONT_MARK | {2'd0, cp[11:6]};
			job.bytes[3] = CONT_MARK | {2'd0, cp[5:0]};
			job.count    = BYTE_IDX_W'(4);
		end else if (held_valid_q) begin
			job.bytes[0] = flush_bytes[0];
			job.bytes[1] = flush_bytes[1];
			job.bytes[2] = flush_bytes[2];
			job.bytes[3] = new_bytes[0];
			job.bytes[4] = new_bytes[1];
			job.bytes[5] = new_bytes[2];
			job.count    = BYTE_IDX_W'(3) + BYTE_IDX_W'(new_count);
		end else begin
			job.bytes[0] = new_bytes[0];
			job.bytes[1] = new_bytes[1];
			job.bytes[2] = new_bytes[2];
			job.count    = BYTE_IDX_W'(new_count);
		end
	end

	assign push = accept && (job.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_high_q  <= '0;
		end else if (accept) begin
			if (!pair && hold_new) begin
				held_valid_q <= 1'b1;
				held_high_q  <= code_unit[9:0];
			end else begin
				held_valid_q <= 1'b0;
				held_high_q  <= '0;
			end
		end
	end

endmodule : u16u8_front
`default_nettype wire

// ===== rtl/u16u8_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// u16u8_queue
// short job queue between front and back
// ---------------------------------------------------------------------------
module u16u8_queue #(
	parameter int unsigned DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire u16u8_pkg::u16u8_job_t push_job,
	input  wire logic                  pop,
	output u16u8_pkg::u16u8_job_t      head,
	output u16u8_pkg::u16u8_qstat_t    qstat
);
	import u16u8_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	u16u8_job_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !push) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> !pop) else $error("pop from empty queue");
`endif

endmodule : u16u8_queue
`default_nettype wire

// ===== rtl/u16u8_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// u16u8_back
// walks the head job one byte per cycle into the output register while the output is not stalled
// ---------------------------------------------------------------------------
module u16u8_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire u16u8_pkg::u16u8_job_t   head,
	input  wire u16u8_pkg::u16u8_qstat_t qstat,
	output logic                         pop,
	output logic                         byte_valid,
	input  wire logic                    byte_stall,
	output logic [7:0]                   out_byte,
	output logic                         run_last,
	output logic                         string_end
);
	import u16u8_pkg::*;

	logic [BYTE_IDX_W-1:0] idx_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  run_last_q;
	logic                  string_end_q;
	logic                  load;
	logic                  last_byte;

	assign load      = (!out_valid_q || !byte_stall) && !qstat.empty;
	assign last_byte = (idx_q == head.count - 1'b1);
	assign pop       = load && last_byte;

	assign byte_valid = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= head.bytes[idx_q];
			run_last_q   <= last_byte;
			string_end_q <= last_byte && head.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!byte_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		!qstat.empty |-> (idx_q < head.count)) else $error("byte index past job");
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> (idx_q == '0)) else $error("byte index left over");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && string_end_q) |-> run_last_q) else $error("string end not last");
`endif

endmodule : u16u8_back
`default_nettype wire
